### sv/lcwc_pkg.sv
// Shared types, widths and constants for the load cell weight conditioner.
`default_nettype none

package lcwc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int WEIGHT_W   = 32;
    localparam int CAL_W      = 24;
    localparam int RUN_W      = 16;
    localparam int TARE_CNT_W = 9;
    localparam int ACC_W      = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int DIV_W      = SAMPLE_W + FRAC_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TARE_CNT_W-1:0] TARE_MAX = TARE_CNT_W'(256);

    localparam logic [CAL_W-1:0]      CAL_FACTOR_RST    = CAL_W'(256);
    localparam logic [WEIGHT_W-1:0]   WEIGHT_DELTA_RST  = WEIGHT_W'(256);
    localparam logic [RUN_W-1:0]      STABLE_CYCLES_RST = RUN_W'(5);
    localparam logic [WEIGHT_W-1:0]   PRESENT_THR_RST   = WEIGHT_W'(2560);
    localparam logic [TARE_CNT_W-1:0] TARE_COUNT_RST    = TARE_CNT_W'(16);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CAL_FACTOR    = 3'd0,
        CFG_WEIGHT_DELTA  = 3'd1,
        CFG_STABLE_CYCLES = 3'd2,
        CFG_PRESENT_THR   = 3'd3,
        CFG_TARE_COUNT    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_WEIGH = 1'b0,
        OP_TARE  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_POST,
        ST_EMIT
    } lcwc_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [CAL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### sv/lcwc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module lcwc_div (
    input  wire                aclk,
    input  wire                aresetn,
    input  lcwc_pkg::div_req_t req,
    output lcwc_pkg::div_rsp_t rsp
);
    import lcwc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CAL_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [CAL_W-1:0]     dsor_reg, dsor_next;

    logic [CAL_W:0]       rem_sh;
    logic [CAL_W+1:0]     trial;
    logic                 borrow;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, dsor_reg};
        borrow = trial[CAL_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsor_next = req.divisor;
        end else if (busy_reg) begin
            // keep the shifted remainder on borrow, else take the difference
            rem_next = borrow ? rem_sh[CAL_W-1:0] : trial[CAL_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~borrow};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### sv/load_cell_weight_conditioner.sv
// Top level of the load cell weight conditioner: sequencer, state and output register.
`default_nettype none

// Each request carries one signed 24-bit converter sample and is either a weigh or a tare
// accumulate; every request yields exactly one result. A weigh computes
// ((sample - offset) << 16) / cal_factor as unsigned Q16.16 grams, clamped at zero and
// saturated at 32 bits, then updates the steady-reading run and reports present and stable.
// A tare adds the sample to a running sum; on the request that reaches tare_count samples the
// offset becomes the sum divided by the count, truncated toward zero, and tare_done is set.
// A timed-out sample is replaced by the current offset. One request is worked on at a time:
// s_tready is high only while the sequencer is idle. A weigh with a positive difference and a
// nonzero cal_factor runs through the shared 40-step restoring divider (states PREP, START,
// DIV, POST, EMIT); a completing tare also uses the divider (PREP, START, DIV, EMIT). Any
// other weigh passes PREP, START, POST, EMIT and any other tare PREP, START, EMIT. The result
// sits in an output register, so the next request is taken while an earlier result still
// waits on m_tready; a finished request then holds in the sequencer until that register is
// free. Configuration writes are taken at any edge with cfg_wr_en high and must only happen
// while the block is idle.

module load_cell_weight_conditioner (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration write port
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata,
    // request channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [23:0] raw_sample
    input  wire  [1:0]  s_tuser,   // [0] opcode, [1] sample_timeout
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] weight_grams, [32] stable, [33] present, zero pad
    output logic [1:0]  m_tuser    // [0] is_weight, [1] tare_done
);
    import lcwc_pkg::*;

    lcwc_state_t state_reg, state_next;

    // configuration registers
    logic [CAL_W-1:0]      cal_factor_reg;
    logic [WEIGHT_W-1:0]   weight_delta_reg;
    logic [RUN_W-1:0]      stable_cycles_reg;
    logic [WEIGHT_W-1:0]   present_thr_reg;
    logic [TARE_CNT_W-1:0] tare_count_reg;

    // persistent state
    logic signed [SAMPLE_W-1:0] offset_reg, offset_next;
    logic [WEIGHT_W-1:0]        prev_weight_reg, prev_weight_next;
    logic [RUN_W-1:0]           steady_run_reg, steady_run_next;
    logic signed [ACC_W-1:0]    tare_acc_reg, tare_acc_next;
    logic [TARE_CNT_W-1:0]      tare_taken_reg, tare_taken_next;

    // per-request working registers
    logic                       op_reg, op_next;
    logic signed [SAMPLE_W-1:0] samp_reg, samp_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic [WEIGHT_W-1:0]        weight_reg, weight_next;
    logic [WEIGHT_W-1:0]        delta_reg, delta_next;
    logic                       tare_done_reg, tare_done_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [WEIGHT_W-1:0] m_weight_reg, m_weight_next;
    logic                m_stable_reg, m_stable_next;
    logic                m_present_reg, m_present_next;
    logic                m_is_weight_reg, m_is_weight_next;
    logic                m_tare_done_reg, m_tare_done_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  s_accept;
    logic                  out_free;
    logic [TARE_CNT_W-1:0] need;
    logic [ACC_W-1:0]      acc_mag;
    logic [RUN_W-1:0]      run_new;
    logic                  present_new;
    logic [SAMPLE_W-1:0]   avg_mag;

    lcwc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // out-of-range tare counts: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (tare_count_reg == '0) begin
            need = TARE_CNT_W'(1);
        end else if (tare_count_reg > TARE_MAX) begin
            need = TARE_MAX;
        end else begin
            need = tare_count_reg;
        end
    end

    assign acc_mag = tare_acc_reg[ACC_W-1] ? ACC_W'(-tare_acc_reg) : ACC_W'(tare_acc_reg);
    assign avg_mag = div_rsp.quotient[SAMPLE_W-1:0];

    // steady run and flags from the registered weight and change
    always_comb begin
        if (delta_reg < weight_delta_reg) begin
            run_new = (steady_run_reg == '1) ? steady_run_reg : steady_run_reg + 1'b1;
        end else begin
            run_new = '0;
        end
        present_new = (weight_reg > present_thr_reg);
    end

    always_comb begin
        state_next       = state_reg;
        offset_next      = offset_reg;
        prev_weight_next = prev_weight_reg;
        steady_run_next  = steady_run_reg;
        tare_acc_next    = tare_acc_reg;
        tare_taken_next  = tare_taken_reg;
        op_next          = op_reg;
        samp_next        = samp_reg;
        diff_next        = diff_reg;
        weight_next      = weight_reg;
        delta_next       = delta_reg;
        tare_done_next   = tare_done_reg;
        m_weight_next    = m_weight_reg;
        m_stable_next    = m_stable_reg;
        m_present_next   = m_present_reg;
        m_is_weight_next = m_is_weight_reg;
        m_tare_done_next = m_tare_done_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        div_req.start    = 1'b0;
        div_req.dividend = {diff_reg[SAMPLE_W-1:0], FRAC_SHIFT'(0)};
        div_req.divisor  = cal_factor_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next   = s_tuser[0];
                    // substitute the offset for a timed-out sample
                    samp_next = s_tuser[1] ? offset_reg : $signed(s_tdata);
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                tare_done_next = 1'b0;
                if (op_reg == OP_WEIGH) begin
                    diff_next = DIFF_W'(samp_reg) - DIFF_W'(offset_reg);
                end else begin
                    tare_acc_next   = tare_acc_reg + ACC_W'(samp_reg);
                    tare_taken_next = tare_taken_reg + 1'b1;
                end
                state_next = ST_START;
            end
            ST_START: begin
                if (op_reg == OP_WEIGH) begin
                    if (diff_reg[DIFF_W-1] || diff_reg == '0) begin
                        weight_next = '0;
                        state_next  = ST_POST;
                    end else if (cal_factor_reg == '0) begin
                        weight_next = '1;
                        state_next  = ST_POST;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else begin
                    if (tare_taken_reg >= need) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(acc_mag);
                        div_req.divisor  = CAL_W'(need);
                        state_next       = ST_DIV;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (op_reg == OP_WEIGH) begin
                        // saturate a quotient that overflows 32 bits
                        weight_next = (div_rsp.quotient[DIV_W-1:WEIGHT_W] != '0)
                                    ? '1 : div_rsp.quotient[WEIGHT_W-1:0];
                        state_next  = ST_POST;
                    end else begin
                        offset_next      = tare_acc_reg[ACC_W-1] ? $signed(-avg_mag)
                                                                 : $signed(avg_mag);
                        prev_weight_next = '0;
                        steady_run_next  = '0;
                        tare_acc_next    = '0;
                        tare_taken_next  = '0;
                        tare_done_next   = 1'b1;
                        state_next       = ST_EMIT;
                    end
                end
            end
            ST_POST: begin
                delta_next = (weight_reg >= prev_weight_reg) ? weight_reg - prev_weight_reg
                                                            : prev_weight_reg - weight_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (op_reg == OP_WEIGH) begin
                        steady_run_next  = run_new;
                        prev_weight_next = weight_reg;
                        m_weight_next    = weight_reg;
                        m_present_next   = present_new;
                        m_stable_next    = present_new && (run_new >= stable_cycles_reg);
                        m_is_weight_next = 1'b1;
                        m_tare_done_next = 1'b0;
                    end else begin
                        m_weight_next    = '0;
                        m_present_next   = 1'b0;
                        m_stable_next    = 1'b0;
                        m_is_weight_next = 1'b0;
                        m_tare_done_next = tare_done_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_factor_reg    <= CAL_FACTOR_RST;
            weight_delta_reg  <= WEIGHT_DELTA_RST;
            stable_cycles_reg <= STABLE_CYCLES_RST;
            present_thr_reg   <= PRESENT_THR_RST;
            tare_count_reg    <= TARE_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CAL_FACTOR:    cal_factor_reg    <= cfg_wdata[CAL_W-1:0];
                CFG_WEIGHT_DELTA:  weight_delta_reg  <= cfg_wdata[WEIGHT_W-1:0];
                CFG_STABLE_CYCLES: stable_cycles_reg <= cfg_wdata[RUN_W-1:0];
                CFG_PRESENT_THR:   present_thr_reg   <= cfg_wdata[WEIGHT_W-1:0];
                CFG_TARE_COUNT:    tare_count_reg    <= cfg_wdata[TARE_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            prev_weight_reg <= '0;
            steady_run_reg  <= '0;
            tare_acc_reg    <= '0;
            tare_taken_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            offset_reg      <= offset_next;
            prev_weight_reg <= prev_weight_next;
            steady_run_reg  <= steady_run_next;
            tare_acc_reg    <= tare_acc_next;
            tare_taken_reg  <= tare_taken_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        samp_reg        <= samp_next;
        diff_reg        <= diff_next;
        weight_reg      <= weight_next;
        delta_reg       <= delta_next;
        tare_done_reg   <= tare_done_next;
        m_weight_reg    <= m_weight_next;
        m_stable_reg    <= m_stable_next;
        m_present_reg   <= m_present_next;
        m_is_weight_reg <= m_is_weight_next;
        m_tare_done_reg <= m_tare_done_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, m_present_reg, m_stable_reg, m_weight_reg};
    assign m_tuser  = {m_tare_done_reg, m_is_weight_reg};

endmodule

`default_nettype wire

### sv/lcwc_checker.sv
// Port-level checks for the load cell weight conditioner, bound to the top level.
`default_nettype none

module lcwc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // one request in flight: ready drops right after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // a tare result carries no weight or flags
    a_tare_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[33:0] == 34'd0))
        else $error("tare result carries weight or flags");

    // only a tare result may report a completed tare
    a_done_only_tare: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
        else $error("weigh result reports tare completion");

    // stable implies present
    a_stable_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> m_tdata[33])
        else $error("stable reported without present");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind load_cell_weight_conditioner lcwc_checker u_lcwc_checker (.*);

`default_nettype wire

### bench/load_cell_weight_conditioner_tb.sv
// Self-checking testbench for the load cell weight conditioner.
module load_cell_weight_conditioner_tb;
    import lcwc_pkg::*;

    // Hold the run to a bounded number of cycles without any handshake progress.
    localparam int STALL_LIMIT = 4000;
    // Result-side hold-off: its length in cycles.
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SESSIONS = 12;
    localparam int SESSION_ITEMS = 88;
    localparam longint WEIGHT_SAT = 64'h0000_0000_FFFF_FFFF;
    localparam longint SAMPLE_HI = 8388607;
    localparam longint SAMPLE_LO = -8388608;

    // One request as it travels on the input channel.
    typedef struct packed {
        opcode_t             op;
        logic [SAMPLE_W-1:0] raw;
        logic                timeout;
    } sample_req_t;

    // One result as the block reports it.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_grams;
        logic                stable;
        logic                present;
        logic                is_weight;
        logic                tare_done;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [23:0] raw_sample
    logic [1:0]  s_tuser = '0;   // [0] opcode, [1] sample_timeout
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] weight_grams, [32] stable, [33] present, zero pad
    logic [1:0]  m_tuser;        // [0] is_weight, [1] tare_done

    load_cell_weight_conditioner u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register shadows, kept in step with every configuration write.
    logic [CAL_W-1:0]      cal_q      = CAL_FACTOR_RST;
    logic [WEIGHT_W-1:0]   delta_q    = WEIGHT_DELTA_RST;
    logic [RUN_W-1:0]      stable_q   = STABLE_CYCLES_RST;
    logic [WEIGHT_W-1:0]   thr_q      = PRESENT_THR_RST;
    logic [TARE_CNT_W-1:0] tare_cnt_q = TARE_COUNT_RST;

    // Conditioner state as the predictor sees it after every accepted request.
    logic signed [SAMPLE_W-1:0] tare_offset = '0;
    logic [WEIGHT_W-1:0]        last_weight = '0;
    logic [RUN_W-1:0]           steady_run  = '0;
    longint                     tare_sum    = 0;
    int                         tare_taken  = 0;

    sample_req_t requests_pending[$];
    reading_t    readings_due[$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count = 0;
    int          reported = 0;
    int          results_seen = 0;
    int          holdoff_left = 0;
    int          stuck_cycles = 0;

    // Work out the result of one request and advance the predicted state.
    function automatic reading_t condition_sample(input opcode_t op,
                                                  input logic signed [SAMPLE_W-1:0] raw,
                                                  input logic timeout);
        longint          smp;
        longint          diff;
        longint          quot;
        logic [WEIGHT_W-1:0] w;
        logic [WEIGHT_W-1:0] step;
        int              need;
        reading_t        r;
        r = '0;
        // A timed-out conversion reads as the current offset.
        smp = timeout ? longint'(tare_offset) : longint'(raw);
        if (op == OP_WEIGH) begin
            diff = smp - longint'(tare_offset);
            if (diff <= 0) begin
                w = '0;
            end else if (cal_q == '0) begin
                // Divide by zero: any positive difference saturates.
                w = '1;
            end else begin
                quot = (diff <<< FRAC_SHIFT) / longint'(cal_q);
                w = (quot > WEIGHT_SAT) ? '1 : quot[WEIGHT_W-1:0];
            end
            step = (w >= last_weight) ? w - last_weight : last_weight - w;
            if (step < delta_q) begin
                if (steady_run != '1) steady_run++;
            end else begin
                steady_run = '0;
            end
            last_weight = w;
            r.weight_grams = w;
            r.present = (w > thr_q);
            r.stable = (steady_run >= stable_q) && r.present;
            r.is_weight = 1'b1;
        end else begin
            // Zero acts as one, anything above the cap acts as the cap.
            need = int'(tare_cnt_q);
            if (need == 0) need = 1;
            if (need > int'(TARE_MAX)) need = int'(TARE_MAX);
            tare_sum += smp;
            tare_taken++;
            // Compare with the count in force now, so a lowered count finishes at once.
            if (tare_taken >= need) begin
                tare_offset = SAMPLE_W'(tare_sum / longint'(need));
                last_weight = '0;
                steady_run = '0;
                tare_sum = 0;
                tare_taken = 0;
                r.tare_done = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_sample(input longint v);
        if (v > SAMPLE_HI) v = SAMPLE_HI;
        else if (v < SAMPLE_LO) v = SAMPLE_LO;
        return v[SAMPLE_W-1:0];
    endfunction

    // Request driver: offer queued requests, predict each one as it is taken.
    always @(posedge aclk) begin
        sample_req_t on_wire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                readings_due = {readings_due, condition_sample(on_wire.op, on_wire.raw,
                                                               on_wire.timeout)};
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = requests_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_wire.raw;
                    s_tuser  <= {on_wire.timeout, on_wire.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken result with the oldest prediction.
    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.weight_grams = m_tdata[31:0];
                got.stable = m_tdata[32];
                got.present = m_tdata[33];
                got.is_weight = m_tuser[0];
                got.tare_done = m_tuser[1];
                if (readings_due.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        $display("unexpected result %0d: weight=%08h stable=%0b present=%0b "
                                 , results_seen, got.weight_grams, got.stable, got.present,
                                 "is_weight=%0b tare_done=%0b", got.is_weight, got.tare_done);
                        reported++;
                    end
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (reported < 10) begin
                            $display("result %0d mismatch: weight exp %08h got %08h, ",
                                     results_seen, want.weight_grams, got.weight_grams,
                                     "stable exp %0b got %0b, present exp %0b got %0b, ",
                                     want.stable, got.stable, want.present, got.present,
                                     "is_weight exp %0b got %0b, tare_done exp %0b got %0b",
                                     want.is_weight, got.is_weight,
                                     want.tare_done, got.tare_done);
                            reported++;
                        end
                    end
                end
                results_seen++;
                // Hold off long enough for the output register and the sequencer to fill.
                if (results_seen == 200 || results_seen == 900) holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: drop the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("FAIL load_cell_weight_conditioner");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_sample(input opcode_t op, input logic [SAMPLE_W-1:0] raw,
                                input logic timeout);
        sample_req_t req;
        req.op = op;
        req.raw = raw;
        req.timeout = timeout;
        requests_pending = {requests_pending, req};
        items_queued++;
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic wait_drained;
        do @(negedge aclk);
        while (items_taken != items_queued || readings_due.size() != 0);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_CAL_FACTOR:    cal_q = value[CAL_W-1:0];
            CFG_WEIGHT_DELTA:  delta_q = value;
            CFG_STABLE_CYCLES: stable_q = value[RUN_W-1:0];
            CFG_PRESENT_THR:   thr_q = value;
            CFG_TARE_COUNT:    tare_cnt_q = value[TARE_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Random session content: mostly weigh runs around a load and complete tares,
    // with some full-range noise and partial tares mixed in.
    task automatic fill_session(input int target, input int need, input longint zero_pt);
        int     n;
        int     len;
        int     kind;
        int     amp;
        bit     big_tare_done;
        longint base;
        n = 0;
        big_tare_done = (need <= 32);
        while (n < target) begin
            kind = big_tare_done ? $urandom_range(0, 9) : 9;
            if (kind >= 6 && kind <= 7 && need > 32) kind = 8;
            if (big_tare_done && kind == 9) kind = 8;
            case ($urandom_range(0, 3))
                0: amp = 0;
                1: amp = 1;
                2: amp = 4;
                default: amp = 40;
            endcase
            if (kind <= 5) begin
                if (kind == 0)
                    base = zero_pt + longint'(signed'(24'($urandom)));
                else
                    base = zero_pt + longint'($urandom_range(0, 200000));
                len = $urandom_range(3, 20);
                repeat (len)
                    queue_sample(OP_WEIGH,
                                 to_sample(base + longint'($urandom_range(0, 2 * amp)) - amp),
                                 $urandom_range(0, 19) == 0);
            end else if (kind <= 7 || kind == 9) begin
                len = need;
                repeat (len)
                    queue_sample(OP_TARE,
                                 to_sample(zero_pt + longint'($urandom_range(0, 2 * amp))
                                           - amp),
                                 $urandom_range(0, 15) == 0);
                big_tare_done = 1'b1;
            end else begin
                len = $urandom_range(1, 4);
                repeat (len)
                    queue_sample(opcode_t'($urandom_range(0, 1)), 24'($urandom),
                                 1'($urandom_range(0, 1)));
            end
            n += len;
        end
    endtask

    initial begin
        int          sess;
        int          need;
        longint      zero_pt;
        longint      t;
        logic [31:0] cal_v;
        logic [31:0] delta_v;
        logic [31:0] stab_v;
        logic [31:0] thr_v;
        logic [31:0] tcnt_v;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 33;
        recv_idle_pct = 74;

        // Directed: field extremes and timeout under the reset settings, then a steady
        // run long enough to report stable.
        queue_sample(OP_WEIGH, 24'h000000, 1'b0);
        queue_sample(OP_WEIGH, 24'h7FFFFF, 1'b0);
        queue_sample(OP_WEIGH, 24'h800000, 1'b0);
        queue_sample(OP_WEIGH, 24'h7FFFFF, 1'b1);
        repeat (6) queue_sample(OP_WEIGH, 24'd100, 1'b0);
        wait_drained();

        // Smallest factor: push the quotient past 32 bits, and just below.
        cfg_write(CFG_CAL_FACTOR, 32'd1);
        end_writes();
        queue_sample(OP_WEIGH, 24'h7FFFFF, 1'b0);
        queue_sample(OP_WEIGH, 24'h010000, 1'b0);
        queue_sample(OP_WEIGH, 24'h00FFFF, 1'b0);
        wait_drained();

        // Zero factor behaves as a divide by zero.
        cfg_write(CFG_CAL_FACTOR, 32'd0);
        end_writes();
        queue_sample(OP_WEIGH, 24'h000001, 1'b0);
        queue_sample(OP_WEIGH, 24'h000000, 1'b0);
        queue_sample(OP_WEIGH, 24'hFFFFFF, 1'b0);
        wait_drained();

        // Tare count of zero completes on a single request; weigh against the new offset.
        cfg_write(CFG_CAL_FACTOR, 32'd256);
        cfg_write(CFG_TARE_COUNT, 32'd0);
        end_writes();
        queue_sample(OP_TARE, 24'hFFFFFB, 1'b0);
        queue_sample(OP_WEIGH, 24'hFFFFFB, 1'b0);
        queue_sample(OP_WEIGH, 24'hFFFFFC, 1'b0);
        queue_sample(OP_WEIGH, 24'h123456, 1'b1);
        wait_drained();

        // Lower the count in the middle of a tare: the next tare request finishes it.
        cfg_write(CFG_TARE_COUNT, 32'd3);
        end_writes();
        queue_sample(OP_TARE, 24'h000007, 1'b0);
        queue_sample(OP_TARE, 24'h654321, 1'b1);
        wait_drained();
        cfg_write(CFG_TARE_COUNT, 32'd1);
        end_writes();
        queue_sample(OP_TARE, 24'hFFFFF8, 1'b0);
        wait_drained();

        // Negative average rounds toward zero.
        cfg_write(CFG_TARE_COUNT, 32'd2);
        end_writes();
        queue_sample(OP_TARE, 24'hFFFFFD, 1'b0);
        queue_sample(OP_TARE, 24'h000000, 1'b0);
        queue_sample(OP_WEIGH, 24'h000000, 1'b0);

        // Random sessions, each under its own register settings.
        for (sess = 0; sess < SESSIONS; sess++) begin
            wait_drained();
            case (sess / 4)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            cal_v = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                                : $urandom_range(1, 65535);
            delta_v = 32'((longint'($urandom_range(1, 16)) << 16) / longint'(cal_v));
            t = (longint'($urandom_range(0, 150000)) << 16) / longint'(cal_v);
            thr_v = (t > WEIGHT_SAT) ? 32'hFFFF_FFFF : t[31:0];
            stab_v = $urandom_range(0, 8);
            tcnt_v = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 12);
            // Pin the extremes in the first few sessions.
            case (sess)
                0: begin
                    cal_v = 32'h00FF_FFFF;
                    delta_v = 32'd0;
                    stab_v = 32'd65535;
                    thr_v = 32'd0;
                    tcnt_v = 32'd1;
                end
                1: begin
                    cal_v = 32'd1;
                    delta_v = 32'hFFFF_FFFF;
                    stab_v = 32'd0;
                    thr_v = 32'hFFFF_FFFF;
                    tcnt_v = 32'd256;
                end
                2: tcnt_v = 32'd511;
                3: tcnt_v = 32'd0;
                default: ;
            endcase

            cfg_write(CFG_CAL_FACTOR, cal_v);
            cfg_write(CFG_WEIGHT_DELTA, delta_v);
            cfg_write(CFG_STABLE_CYCLES, stab_v);
            cfg_write(CFG_PRESENT_THR, thr_v);
            cfg_write(CFG_TARE_COUNT, tcnt_v);
            end_writes();

            need = int'(tcnt_v[TARE_CNT_W-1:0]);
            if (need == 0) need = 1;
            if (need > int'(TARE_MAX)) need = int'(TARE_MAX);
            zero_pt = longint'($urandom_range(0, 2000000)) - 1000000;
            fill_session(SESSION_ITEMS, need, zero_pt);
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        fail_count += readings_due.size();
        if (fail_count == 0) begin
            $display("PASS load_cell_weight_conditioner");
        end else begin
            $display("FAIL load_cell_weight_conditioner");
        end
        $finish;
    end

endmodule
